FILE: rtl/core/ledtw_pkg.sv
// ----------------------------------------------------------------------------
// ledtw_pkg
// Shared types and constants for the two-wire LED and key master.
// ----------------------------------------------------------------------------
package ledtw_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_DIGIT = 2'd1,
    KIND_DUTY  = 2'd2,
    KIND_KEYS  = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_TABLE    = 2'd0;
  localparam logic [1:0] MODE_TABLE_DP = 2'd1;
  localparam logic [1:0] MODE_RAW      = 2'd2;

  localparam logic       CFG_ACK_TIMEOUT = 1'b0;
  localparam logic       CFG_NO_KEY_CODE = 1'b1;

  localparam logic [7:0] FRAME_DATA_CMD  = 8'h40;
  localparam logic [7:0] FRAME_READ_CMD  = 8'h42;
  localparam logic [4:0] FRAME_ADDR_BASE = 5'b11000;  // 0xC0 with position in bits 2:0
  localparam logic [7:0] FRAME_CTRL_OFF  = 8'h80;
  localparam logic [7:0] CTRL_ON_BIT     = 8'h08;
  localparam logic [7:0] SEG_DP_BIT      = 8'h80;
  localparam logic [7:0] GLYPH_BLANK     = 8'd16;
  localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;
  localparam int         FIFO_DEPTH      = 2;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame0;
    logic [7:0] frame1;
    logic [7:0] frame2;
    logic       dio;
  } item_t;

  function automatic logic [7:0] seg_lookup(input logic [4:0] idx);
    logic [7:0] seg;
    case (idx)
      5'd0:  seg = 8'h3f;
      5'd1:  seg = 8'h06;
      5'd2:  seg = 8'h5b;
      5'd3:  seg = 8'h4f;
      5'd4:  seg = 8'h66;
      5'd5:  seg = 8'h6d;
      5'd6:  seg = 8'h7d;
      5'd7:  seg = 8'h07;
      5'd8:  seg = 8'h7f;
      5'd9:  seg = 8'h6f;
      5'd10: seg = 8'h77;
      5'd11: seg = 8'h7C;
      5'd12: seg = 8'h39;
      5'd13: seg = 8'h5E;
      5'd14: seg = 8'h79;
      5'd15: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/core/ledtw_front.sv
// ----------------------------------------------------------------------------
// ledtw_front
// Accepts input words and builds the frame bytes a command would send.
// ----------------------------------------------------------------------------
module ledtw_front
  import ledtw_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [2:0] digit_position,
  input  logic [7:0] glyph,
  input  logic [1:0] char_mode,
  input  logic [3:0] brightness,
  input  logic       dio_in,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [4:0] glyph_idx;
  logic [7:0] seg;
  logic [7:0] ctrl;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Table indexes above the last entry saturate to the blank glyph.
  assign glyph_idx = (glyph > GLYPH_BLANK) ? GLYPH_BLANK[4:0] : glyph[4:0];

  always_comb begin
    if (char_mode == MODE_RAW) begin
      seg = glyph;
    end else if (char_mode == MODE_TABLE_DP) begin
      seg = seg_lookup(glyph_idx) | SEG_DP_BIT;
    end else begin
      seg = seg_lookup(glyph_idx);
    end
  end

  assign ctrl = (brightness == 4'd0) ? FRAME_CTRL_OFF :
                (FRAME_CTRL_OFF | CTRL_ON_BIT | {5'd0, 3'(brightness - 4'd1)});

  always_comb begin
    q_item.kind   = kind_t'(kind);
    q_item.frame1 = {FRAME_ADDR_BASE, digit_position};
    q_item.frame2 = seg;
    q_item.dio    = dio_in;
    case (kind_t'(kind))
      KIND_DIGIT: q_item.frame0 = FRAME_DATA_CMD;
      KIND_DUTY:  q_item.frame0 = ctrl;
      KIND_KEYS:  q_item.frame0 = FRAME_READ_CMD;
      default:    q_item.frame0 = 8'h00;
    endcase
  end

endmodule

FILE: rtl/core/ledtw_fifo.sv
// ----------------------------------------------------------------------------
// ledtw_fifo
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module ledtw_fifo
  import ledtw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  localparam int PtrW = $clog2(FIFO_DEPTH);

  item_t           entries [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign full      = (count == (PtrW+1)'(FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (PtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PtrW+1)'(1);
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= (PtrW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/core/ledtw_back.sv
// ----------------------------------------------------------------------------
// ledtw_back
// Bus phase sequencer: one word per cycle unless stalled, result held in an output register.
// ----------------------------------------------------------------------------
module ledtw_back
  import ledtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clk_level,
  output logic        dio_level,
  output logic        dio_drive,
  output logic        busy_res,
  output logic        key_valid,
  output logic [7:0]  key_code,
  output logic        key_changed
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_WAIT,
    PH_ACK_HIGH, PH_RD_LOW, PH_RD_HIGH, PH_ACK2_WAIT, PH_ACK2_HIGH,
    PH_STOP_A, PH_STOP_B
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next, bit_count_inc;
  logic [7:0]  tx_shift, tx_shift_next;
  logic [7:0]  frame_bytes [3];
  logic [1:0]  byte_index, byte_index_next, sel_idx;
  logic [1:0]  frames_left, frames_left_next;
  logic [15:0] wait_count, wait_count_next, wait_inc;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [7:0]  previous_key, previous_key_next;
  logic        key_job, key_job_next;
  logic [15:0] ack_timeout;
  logic [7:0]  frame_sel;
  logic        load_frames;
  logic        clk_o, dlev_o, drive_o, kvalid_o, kchg_o;
  logic [7:0]  code;

  assign q_pop         = q_valid && (!out_valid || out_ready);
  assign bit_count_inc = bit_count + 4'd1;
  assign wait_inc      = wait_count + 16'd1;
  assign code          = ~rx_shift;
  // Start loads the current byte; a follow-on byte inside a frame is the next one.
  assign sel_idx       = (phase == PH_START_A) ? byte_index : byte_index + 2'd1;

  always_comb begin
    case (sel_idx)
      2'd0:    frame_sel = frame_bytes[0];
      2'd1:    frame_sel = frame_bytes[1];
      2'd2:    frame_sel = frame_bytes[2];
      default: frame_sel = 8'h00;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    tx_shift_next     = tx_shift;
    byte_index_next   = byte_index;
    frames_left_next  = frames_left;
    wait_count_next   = wait_count;
    rx_shift_next     = rx_shift;
    previous_key_next = previous_key;
    key_job_next      = key_job;
    load_frames       = 1'b0;
    clk_o             = 1'b1;
    dlev_o            = 1'b1;
    drive_o           = 1'b1;
    kvalid_o          = 1'b0;
    kchg_o            = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (q_item.kind != KIND_TICK) begin
          byte_index_next  = 2'd0;
          key_job_next     = (q_item.kind == KIND_KEYS);
          frames_left_next = (q_item.kind == KIND_DIGIT) ? 2'd2 : 2'd0;
          load_frames      = 1'b1;
          phase_next       = PH_START_A;
        end
      end
      PH_START_A: begin
        tx_shift_next  = frame_sel;
        bit_count_next = 4'd0;
        phase_next     = PH_START_B;
      end
      PH_START_B: begin
        dlev_o     = 1'b0;
        phase_next = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        clk_o      = 1'b0;
        dlev_o     = tx_shift[0];
        phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        dlev_o         = tx_shift[0];
        tx_shift_next  = {1'b0, tx_shift[7:1]};
        bit_count_next = bit_count_inc;
        if (bit_count_inc >= 4'd8) begin
          wait_count_next = 16'd0;
          phase_next      = PH_ACK_WAIT;
        end else begin
          phase_next = PH_BIT_LOW;
        end
      end
      PH_ACK_WAIT, PH_ACK2_WAIT: begin
        clk_o   = 1'b0;
        dlev_o  = 1'b0;
        drive_o = 1'b0;
        if (q_item.dio) begin
          wait_count_next = wait_inc;
        end
        // A zero timeout is never matched until the counter wraps.
        if (!q_item.dio || (wait_inc == ack_timeout)) begin
          phase_next = (phase == PH_ACK_WAIT) ? PH_ACK_HIGH : PH_ACK2_HIGH;
        end
      end
      PH_ACK_HIGH: begin
        dlev_o = 1'b0;
        if (key_job) begin
          bit_count_next = 4'd0;
          rx_shift_next  = 8'd0;
          phase_next     = PH_RD_LOW;
        end else if (frames_left != 2'd0 && byte_index != 2'd0) begin
          byte_index_next  = byte_index + 2'd1;
          frames_left_next = frames_left - 2'd1;
          tx_shift_next    = frame_sel;
          bit_count_next   = 4'd0;
          phase_next       = PH_BIT_LOW;
        end else begin
          phase_next = PH_STOP_A;
        end
      end
      PH_RD_LOW: begin
        clk_o      = 1'b0;
        dlev_o     = 1'b0;
        drive_o    = 1'b0;
        phase_next = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        dlev_o         = 1'b0;
        drive_o        = 1'b0;
        rx_shift_next  = {q_item.dio, rx_shift[7:1]};
        bit_count_next = bit_count_inc;
        if (bit_count_inc >= 4'd8) begin
          wait_count_next = 16'd0;
          phase_next      = PH_ACK2_WAIT;
        end else begin
          phase_next = PH_RD_LOW;
        end
      end
      PH_ACK2_HIGH: begin
        dlev_o     = 1'b0;
        phase_next = PH_STOP_A;
      end
      PH_STOP_A: begin
        clk_o      = 1'b0;
        dlev_o     = 1'b0;
        phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        dlev_o = 1'b0;
        if (frames_left != 2'd0) begin
          byte_index_next  = byte_index + 2'd1;
          frames_left_next = frames_left - 2'd1;
          phase_next       = PH_START_A;
        end else begin
          phase_next = PH_IDLE;
          if (key_job) begin
            kvalid_o          = 1'b1;
            kchg_o            = (code != previous_key);
            previous_key_next = code;
            key_job_next      = 1'b0;
          end
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        key_job_next     = 1'b0;
        frames_left_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      clk_level   <= clk_o;
      dio_level   <= dlev_o;
      dio_drive   <= drive_o;
      busy_res    <= (phase_next != PH_IDLE);
      key_valid   <= kvalid_o;
      key_code    <= previous_key_next;
      key_changed <= kchg_o;
      if (load_frames) begin
        frame_bytes[0] <= q_item.frame0;
        frame_bytes[1] <= q_item.frame1;
        frame_bytes[2] <= q_item.frame2;
      end
    end
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= 4'd0;
      tx_shift     <= 8'd0;
      byte_index   <= 2'd0;
      frames_left  <= 2'd0;
      wait_count   <= 16'd0;
      rx_shift     <= 8'd0;
      key_job      <= 1'b0;
      previous_key <= 8'd0;
      ack_timeout  <= ACK_TIMEOUT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        bit_count    <= bit_count_next;
        tx_shift     <= tx_shift_next;
        byte_index   <= byte_index_next;
        frames_left  <= frames_left_next;
        wait_count   <= wait_count_next;
        rx_shift     <= rx_shift_next;
        key_job      <= key_job_next;
        previous_key <= previous_key_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ACK_TIMEOUT) begin
          ack_timeout <= cfg_data;
        end else if (cfg_index == CFG_NO_KEY_CODE) begin
          previous_key <= cfg_data[7:0];
        end
      end
    end
  end

  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (frames_left == 2'd0 && !key_job))
    else $error("idle with a pending frame or key job");

  a_bit_bound : assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'd8)
    else $error("bit counter ran past one byte");

  a_byte_bound : assert property (@(posedge clk) disable iff (rst)
    byte_index <= 2'd2)
    else $error("byte index past the last frame byte");

  a_key_at_end : assert property (@(posedge clk) disable iff (rst)
    (out_valid && key_valid) |-> !busy_res)
    else $error("key result reported while still busy");

endmodule

FILE: rtl/core/led_driver_two_wire_master.sv
// ----------------------------------------------------------------------------
// led_driver_two_wire_master
// Bit-level master for a two-wire LED display and key-scan chip.
// ----------------------------------------------------------------------------
// Each input word is either one bus tick or a command (set digit, set duty,
// read keys). A command is acted on only while the bus is idle; otherwise
// it counts as a tick. Every accepted word yields exactly one output word
// with the clock and data line levels for that tick, the busy flag and the
// key read status.
// Throughput is one word per cycle while the receiver does not stall: the
// front decodes a word into frame bytes, a two-entry queue decouples it
// from the sequencer, and the sequencer advances one bus phase per word
// into an output register. An accepted word passes through the queue and
// then the output register. When the receiver stalls, the output register
// holds, the queue fills, and in_ready drops after two more words.
// Synchronous reset returns the bus to idle, the acknowledge timeout to
// 1000 ticks and the stored key code to zero. Configuration writes take
// effect in the cycle after cfg_we and are meant for idle periods only.
// ----------------------------------------------------------------------------
module led_driver_two_wire_master
  import ledtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [2:0]  digit_position,
  input  logic [7:0]  glyph,
  input  logic [1:0]  char_mode,
  input  logic [3:0]  brightness,
  input  logic        dio_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clk_level,
  output logic        dio_level,
  output logic        dio_drive,
  output logic        busy_res,
  output logic        key_valid,
  output logic [7:0]  key_code,
  output logic        key_changed,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  item_t q_in_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_out_item;

  ledtw_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .digit_position (digit_position),
    .glyph          (glyph),
    .char_mode      (char_mode),
    .brightness     (brightness),
    .dio_in         (dio_in),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  ledtw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_out_item)
  );

  ledtw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .clk_level   (clk_level),
    .dio_level   (dio_level),
    .dio_drive   (dio_drive),
    .busy_res    (busy_res),
    .key_valid   (key_valid),
    .key_code    (key_code),
    .key_changed (key_changed)
  );

endmodule
